>>> rtl/core/segment_intersection_macros.svh
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared property wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// same-cycle implication
`define SI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment_intersection: assertion failed");

// next-cycle implication
`define SI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segment_intersection: assertion failed");

`endif

>>> rtl/core/seg_int_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, constants and types shared by the intersection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package seg_int_pkg;

  localparam int unsigned IW        = 32;
  localparam int unsigned AW        = 33;
  localparam int unsigned MXW       = 65;
  localparam int unsigned MBW       = 66;
  localparam int unsigned CW        = 66;
  localparam int unsigned DW        = 67;
  localparam int unsigned LW        = 33;
  localparam int unsigned PLW       = 67;
  localparam int unsigned PHW       = 66;
  localparam int unsigned PRW       = 99;
  localparam int unsigned NW        = 100;
  localparam int unsigned QW        = 42;
  localparam int unsigned OW        = DW + QW;
  localparam int unsigned TW        = DW + QW - 1;
  localparam int unsigned DIV_LAT   = QW + 1;
  localparam int unsigned VW        = 42;
  localparam int unsigned BW        = 34;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned LIMIT_EXP = 40;
  localparam int unsigned LATENCY   = 7 + DIV_LAT + 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd131;

  typedef struct packed {
    logic signed [IW-1:0] x1lo;
    logic signed [IW-1:0] x1hi;
    logic signed [IW-1:0] y1lo;
    logic signed [IW-1:0] y1hi;
    logic signed [IW-1:0] x2lo;
    logic signed [IW-1:0] x2hi;
    logic signed [IW-1:0] y2lo;
    logic signed [IW-1:0] y2hi;
  } bounds_t;

  typedef struct packed {
    logic    vld;
    logic    par;
    logic    neg_x;
    logic    neg_y;
    bounds_t bnd;
  } side_t;

endpackage

>>> rtl/core/seg_int_div.sv
// ----------------------------------------------------------------------------
// Segment intersection divider
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients at or above 2^QW.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seg_int_div (
  input  logic                        clk_i,
  input  logic [seg_int_pkg::NW-1:0]  num_i,
  input  logic [seg_int_pkg::DW-1:0]  den_i,
  output logic [seg_int_pkg::QW-1:0]  quo_o,
  output logic                        ovf_o
);

  logic [seg_int_pkg::NW-1:0] rem_q [seg_int_pkg::QW+1];
  logic [seg_int_pkg::DW-1:0] den_q [seg_int_pkg::QW+1];
  logic [seg_int_pkg::QW-1:0] quo_q [seg_int_pkg::QW+1];
  logic                       ovf_q [seg_int_pkg::QW+1];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= seg_int_pkg::OW'(num_i) >= {den_i, {seg_int_pkg::QW{1'b0}}};
  end

  for (genvar k = 0; k < seg_int_pkg::QW; k++) begin : g_step
    localparam int unsigned Bit = seg_int_pkg::QW - 1 - k;
    logic [seg_int_pkg::TW-1:0] dsh;
    logic [seg_int_pkg::TW-1:0] rext;
    logic                       take;

    assign dsh  = seg_int_pkg::TW'(den_q[k]) << Bit;
    assign rext = seg_int_pkg::TW'(rem_q[k]);
    assign take = rext >= dsh;

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= take ? seg_int_pkg::NW'(rext - dsh) : rem_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_q[k] | (take ? (seg_int_pkg::QW'(1) << Bit) : '0);
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign quo_o = quo_q[seg_int_pkg::QW];
  assign ovf_o = ovf_q[seg_int_pkg::QW];

endmodule

>>> rtl/core/segment_intersection.sv
// ----------------------------------------------------------------------------
// Segment intersection
// Throughput: one transaction per cycle; busy is never raised, and the
// 43-stage divider sets most of the depth.
// Results cannot be stalled; each shows for one cycle with done_o.
// Reset clears all valid bits and loads tolerance with 131.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_intersection_macros.svh"

module segment_intersection (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [seg_int_pkg::IW-1:0]     seg1_start_x_i,
  input  logic signed [seg_int_pkg::IW-1:0]     seg1_start_y_i,
  input  logic signed [seg_int_pkg::IW-1:0]     seg1_end_x_i,
  input  logic signed [seg_int_pkg::IW-1:0]     seg1_end_y_i,
  input  logic signed [seg_int_pkg::IW-1:0]     seg2_start_x_i,
  input  logic signed [seg_int_pkg::IW-1:0]     seg2_start_y_i,
  input  logic signed [seg_int_pkg::IW-1:0]     seg2_end_x_i,
  input  logic signed [seg_int_pkg::IW-1:0]     seg2_end_y_i,
  input  logic                                  tolerance_we_i,
  input  logic [seg_int_pkg::TOL_W-1:0]         tolerance_i,
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic                                  parallel_o,
  output logic signed [seg_int_pkg::IW-1:0]     cross_x_o,
  output logic signed [seg_int_pkg::IW-1:0]     cross_y_o
);

  localparam int unsigned IW  = seg_int_pkg::IW;
  localparam int unsigned AW  = seg_int_pkg::AW;
  localparam int unsigned NW  = seg_int_pkg::NW;
  localparam int unsigned DW  = seg_int_pkg::DW;
  localparam int unsigned QW  = seg_int_pkg::QW;
  localparam int unsigned VW  = seg_int_pkg::VW;
  localparam int unsigned BW  = seg_int_pkg::BW;
  localparam int unsigned PRW = seg_int_pkg::PRW;
  localparam int unsigned LW  = seg_int_pkg::LW;
  localparam int unsigned MXW = seg_int_pkg::MXW;
  localparam int unsigned MBW = seg_int_pkg::MBW;
  localparam int unsigned PLW = seg_int_pkg::PLW;
  localparam int unsigned PHW = seg_int_pkg::PHW;

  localparam logic [QW-1:0] Limit = QW'(1) << seg_int_pkg::LIMIT_EXP;
  localparam logic signed [VW-1:0] SatMax = VW'(64'sd2147483647);
  localparam logic signed [VW-1:0] SatMin = -VW'(64'sd2147483648);

  function automatic logic signed [IW-1:0] smin(logic signed [IW-1:0] a,
                                                logic signed [IW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [IW-1:0] smax(logic signed [IW-1:0] a,
                                                logic signed [IW-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic in_rng(logic signed [VW-1:0] v, logic signed [IW-1:0] lo,
                                  logic signed [IW-1:0] hi, logic [seg_int_pkg::TOL_W-1:0] tol);
    logic signed [BW-1:0] lo_t;
    logic signed [BW-1:0] hi_t;
    logic signed [BW-1:0] tol_s;
    tol_s = $signed({{(BW - seg_int_pkg::TOL_W){1'b0}}, tol});
    lo_t  = BW'(lo) - tol_s;
    hi_t  = BW'(hi) + tol_s;
    return (v >= VW'(lo_t)) && (v <= VW'(hi_t));
  endfunction

  function automatic logic signed [IW-1:0] sat32(logic signed [VW-1:0] v);
    logic signed [VW-1:0] c;
    c = (v > SatMax) ? SatMax : ((v < SatMin) ? SatMin : v);
    return IW'(c);
  endfunction

  logic [seg_int_pkg::TOL_W-1:0] tol_q;
  logic                          acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= seg_int_pkg::TOL_RESET;
    end else if (tolerance_we_i) begin
      tol_q <= tolerance_i;
    end
  end

  // stage 1: line coefficients and bounds
  logic signed [AW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [IW-1:0] x1a_q, y1a_q, x2a_q, y2a_q;
  seg_int_pkg::bounds_t bnd1_q, bnd1_d;

  always_comb begin
    bnd1_d.x1lo = smin(seg1_start_x_i, seg1_end_x_i);
    bnd1_d.x1hi = smax(seg1_start_x_i, seg1_end_x_i);
    bnd1_d.y1lo = smin(seg1_start_y_i, seg1_end_y_i);
    bnd1_d.y1hi = smax(seg1_start_y_i, seg1_end_y_i);
    bnd1_d.x2lo = smin(seg2_start_x_i, seg2_end_x_i);
    bnd1_d.x2hi = smax(seg2_start_x_i, seg2_end_x_i);
    bnd1_d.y2lo = smin(seg2_start_y_i, seg2_end_y_i);
    bnd1_d.y2hi = smax(seg2_start_y_i, seg2_end_y_i);
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= AW'(seg1_end_y_i) - AW'(seg1_start_y_i);
    b1_q   <= AW'(seg1_start_x_i) - AW'(seg1_end_x_i);
    a2_q   <= AW'(seg2_end_y_i) - AW'(seg2_start_y_i);
    b2_q   <= AW'(seg2_start_x_i) - AW'(seg2_end_x_i);
    x1a_q  <= seg1_start_x_i;
    y1a_q  <= seg1_start_y_i;
    x2a_q  <= seg2_start_x_i;
    y2a_q  <= seg2_start_y_i;
    bnd1_q <= bnd1_d;
  end

  // stage 2: first products
  logic signed [MXW-1:0]  a1x_q, b1y_q, a2x_q, b2y_q;
  logic signed [MBW-1:0]  a1b2_q, a2b1_q;
  logic signed [AW-1:0]   a1_2q, b1_2q, a2_2q, b2_2q;
  seg_int_pkg::bounds_t   bnd2_q;

  always_ff @(posedge clk_i) begin
    a1x_q  <= MXW'(a1_q) * MXW'(x1a_q);
    b1y_q  <= MXW'(b1_q) * MXW'(y1a_q);
    a2x_q  <= MXW'(a2_q) * MXW'(x2a_q);
    b2y_q  <= MXW'(b2_q) * MXW'(y2a_q);
    a1b2_q <= MBW'(a1_q) * MBW'(b2_q);
    a2b1_q <= MBW'(a2_q) * MBW'(b1_q);
    a1_2q  <= a1_q;
    b1_2q  <= b1_q;
    a2_2q  <= a2_q;
    b2_2q  <= b2_q;
    bnd2_q <= bnd1_q;
  end

  // stage 3: constants and determinant
  logic signed [seg_int_pkg::CW-1:0] c1_q, c2_q;
  logic signed [DW-1:0]              det3_q;
  logic signed [AW-1:0]              a1_3q, b1_3q, a2_3q, b2_3q;
  seg_int_pkg::bounds_t              bnd3_q;

  always_ff @(posedge clk_i) begin
    c1_q   <= seg_int_pkg::CW'(a1x_q) + seg_int_pkg::CW'(b1y_q);
    c2_q   <= seg_int_pkg::CW'(a2x_q) + seg_int_pkg::CW'(b2y_q);
    det3_q <= DW'(a1b2_q) - DW'(a2b1_q);
    a1_3q  <= a1_2q;
    b1_3q  <= b1_2q;
    a2_3q  <= a2_2q;
    b2_3q  <= b2_2q;
    bnd3_q <= bnd2_q;
  end

  // stage 4: partial products of the numerators
  logic signed [PLW-1:0]  b2c1l_q, b1c2l_q, a1c2l_q, a2c1l_q;
  logic signed [PHW-1:0]  b2c1h_q, b1c2h_q, a1c2h_q, a2c1h_q;
  logic signed [DW-1:0]   det4_q;
  seg_int_pkg::bounds_t   bnd4_q;
  logic signed [LW:0]     c1l, c2l;
  logic signed [LW-1:0]   c1h, c2h;

  assign c1l = $signed({1'b0, c1_q[LW-1:0]});
  assign c2l = $signed({1'b0, c2_q[LW-1:0]});
  assign c1h = $signed(c1_q[seg_int_pkg::CW-1:LW]);
  assign c2h = $signed(c2_q[seg_int_pkg::CW-1:LW]);

  always_ff @(posedge clk_i) begin
    b2c1l_q <= PLW'(b2_3q) * PLW'(c1l);
    b2c1h_q <= PHW'(b2_3q) * PHW'(c1h);
    b1c2l_q <= PLW'(b1_3q) * PLW'(c2l);
    b1c2h_q <= PHW'(b1_3q) * PHW'(c2h);
    a1c2l_q <= PLW'(a1_3q) * PLW'(c2l);
    a1c2h_q <= PHW'(a1_3q) * PHW'(c2h);
    a2c1l_q <= PLW'(a2_3q) * PLW'(c1l);
    a2c1h_q <= PHW'(a2_3q) * PHW'(c1h);
    det4_q  <= det3_q;
    bnd4_q  <= bnd3_q;
  end

  // stage 5: full products, determinant sign and magnitude
  logic signed [PRW-1:0] b2c1_q, b1c2_q, a1c2_q, a2c1_q;
  logic [DW-1:0]         dabs5_q;
  logic                  dneg5_q, dzero5_q;
  seg_int_pkg::bounds_t  bnd5_q;

  always_ff @(posedge clk_i) begin
    b2c1_q   <= (PRW'(b2c1h_q) <<< LW) + PRW'(b2c1l_q);
    b1c2_q   <= (PRW'(b1c2h_q) <<< LW) + PRW'(b1c2l_q);
    a1c2_q   <= (PRW'(a1c2h_q) <<< LW) + PRW'(a1c2l_q);
    a2c1_q   <= (PRW'(a2c1h_q) <<< LW) + PRW'(a2c1l_q);
    dneg5_q  <= det4_q[DW-1];
    dzero5_q <= (det4_q == '0);
    dabs5_q  <= det4_q[DW-1] ? DW'(-det4_q) : DW'(det4_q);
    bnd5_q   <= bnd4_q;
  end

  // stage 6: numerators
  logic signed [NW-1:0] nx6_q, ny6_q;
  logic [DW-1:0]        dabs6_q;
  logic                 dneg6_q, dzero6_q;
  seg_int_pkg::bounds_t bnd6_q;

  always_ff @(posedge clk_i) begin
    nx6_q    <= NW'(b2c1_q) - NW'(b1c2_q);
    ny6_q    <= NW'(a1c2_q) - NW'(a2c1_q);
    dabs6_q  <= dabs5_q;
    dneg6_q  <= dneg5_q;
    dzero6_q <= dzero5_q;
    bnd6_q   <= bnd5_q;
  end

  // stage 7: magnitudes and quotient signs
  logic [NW-1:0]        nxa_q, nya_q;
  logic [DW-1:0]        dabs7_q;
  seg_int_pkg::side_t   side7_q;
  logic [6:1]           vld_q;

  always_ff @(posedge clk_i) begin
    nxa_q   <= nx6_q[NW-1] ? NW'(-nx6_q) : NW'(nx6_q);
    nya_q   <= ny6_q[NW-1] ? NW'(-ny6_q) : NW'(ny6_q);
    dabs7_q <= dabs6_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      side7_q <= '0;
    end else begin
      vld_q         <= {vld_q[5:1], acc};
      side7_q.vld   <= vld_q[6];
      side7_q.par   <= dzero6_q;
      side7_q.neg_x <= nx6_q[NW-1] ^ dneg6_q;
      side7_q.neg_y <= ny6_q[NW-1] ^ dneg6_q;
      side7_q.bnd   <= bnd6_q;
    end
  end

  // quotients
  logic [QW-1:0] qx, qy;
  logic          ovx, ovy;

  seg_int_div u_div_x (
    .clk_i (clk_i),
    .num_i (nxa_q),
    .den_i (dabs7_q),
    .quo_o (qx),
    .ovf_o (ovx)
  );

  seg_int_div u_div_y (
    .clk_i (clk_i),
    .num_i (nya_q),
    .den_i (dabs7_q),
    .quo_o (qy),
    .ovf_o (ovy)
  );

  seg_int_pkg::side_t side_q [seg_int_pkg::DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < seg_int_pkg::DIV_LAT; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= side7_q;
      for (int i = 1; i < seg_int_pkg::DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stage F1: clamp and sign
  logic [QW-1:0]         mx, my;
  logic signed [VW-1:0]  vx_q, vy_q;
  seg_int_pkg::side_t    sidef_q;

  assign mx = (ovx || (qx > Limit)) ? Limit : qx;
  assign my = (ovy || (qy > Limit)) ? Limit : qy;

  always_ff @(posedge clk_i) begin
    vx_q <= side_q[seg_int_pkg::DIV_LAT-1].neg_x ? -$signed(VW'(mx)) : $signed(VW'(mx));
    vy_q <= side_q[seg_int_pkg::DIV_LAT-1].neg_y ? -$signed(VW'(my)) : $signed(VW'(my));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidef_q <= '0;
    end else begin
      sidef_q <= side_q[seg_int_pkg::DIV_LAT-1];
    end
  end

  // stage F2: range test and output register
  logic hit_d;

  assign hit_d = in_rng(vx_q, sidef_q.bnd.x1lo, sidef_q.bnd.x1hi, tol_q) &&
                 in_rng(vy_q, sidef_q.bnd.y1lo, sidef_q.bnd.y1hi, tol_q) &&
                 in_rng(vx_q, sidef_q.bnd.x2lo, sidef_q.bnd.x2hi, tol_q) &&
                 in_rng(vy_q, sidef_q.bnd.y2lo, sidef_q.bnd.y2hi, tol_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= sidef_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o      <= !sidef_q.par && hit_d;
    parallel_o <= sidef_q.par;
    cross_x_o  <= sidef_q.par ? '0 : sat32(vx_q);
    cross_y_o  <= sidef_q.par ? '0 : sat32(vy_q);
  end

  `SI_ASSERT_IMPL(a_hit_not_par, done_o, !(hit_o && parallel_o))
  `SI_ASSERT_IMPL(a_par_zero, done_o && parallel_o, (cross_x_o == '0) && (cross_y_o == '0))
  `SI_ASSERT_IMPL(a_latency, acc, ##(seg_int_pkg::LATENCY) done_o)
  `SI_ASSERT_NEXT(a_done_src, sidef_q.vld, done_o)

endmodule

>>> tb/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Drives segment pairs through the command interface with random gaps,
// predicts hit, parallel flag and saturated crossing point using exact wide
// integer arithmetic, and compares every done_o strobe in order. The
// tolerance register is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_test;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [seg_int_pkg::IW-1:0] coord_t;
  typedef coord_t pair_t [8];

  typedef struct {
    logic   hit;
    logic   par;
    coord_t cx;
    coord_t cy;
  } crossing_t;

  class crossing_scoreboard;
    crossing_t pending[$];
    logic [seg_int_pkg::TOL_W-1:0] tol;
    int errors;

    function new();
      tol = seg_int_pkg::TOL_RESET;
      errors = 0;
    endfunction

    function wide_t clamp_quot(wide_t q);
      wide_t lim;
      lim = wide_t'(1) <<< seg_int_pkg::LIMIT_EXP;
      if (q > lim) return lim;
      if (q < -lim) return -lim;
      return q;
    endfunction

    function coord_t sat32(wide_t v);
      if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic in_span(wide_t v, wide_t a, wide_t b, wide_t t);
      wide_t lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (lo <= v + t) && (v - t <= hi);
    endfunction

    function void note_segments(pair_t p);
      wide_t w[8];
      wide_t a1, b1, c1, a2, b2, c2, det, nx, ny, qx, qy, t;
      crossing_t e;
      foreach (w[i]) w[i] = p[i];
      t = tol;
      a1 = w[3] - w[1];
      b1 = w[0] - w[2];
      a2 = w[7] - w[5];
      b2 = w[4] - w[6];
      c1 = a1 * w[0] + b1 * w[1];
      c2 = a2 * w[4] + b2 * w[5];
      det = a1 * b2 - a2 * b1;
      if (det == 0) begin
        e = '{hit: 1'b0, par: 1'b1, cx: '0, cy: '0};
      end else begin
        nx = b2 * c1 - b1 * c2;
        ny = a1 * c2 - a2 * c1;
        qx = clamp_quot(nx / det);
        qy = clamp_quot(ny / det);
        e.par = 1'b0;
        e.hit = in_span(qx, w[0], w[2], t) && in_span(qy, w[1], w[3], t) &&
                in_span(qx, w[4], w[6], t) && in_span(qy, w[5], w[7], t);
        e.cx = sat32(qx);
        e.cy = sat32(qy);
      end
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_crossing(logic hit, logic par, coord_t cx, coord_t cy);
      crossing_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) report("hit", hit, e.hit);
      if (par !== e.par) report("parallel", par, e.par);
      if (cx !== e.cx) report("cross_x", cx, e.cx);
      if (cy !== e.cy) report("cross_y", cy, e.cy);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  pair_t seg = '{default: '0};
  logic tolerance_we_i = 1'b0;
  logic [seg_int_pkg::TOL_W-1:0] tolerance_i = '0;
  logic done_o, hit_o, parallel_o;
  coord_t cross_x_o, cross_y_o;

  crossing_scoreboard sb = new();
  int idle_cycles = 0;
  localparam int WATCHDOG_LIMIT = 4 * (seg_int_pkg::LATENCY + 20) + 200;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  segment_intersection i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .seg1_start_x_i (seg[0]),
    .seg1_start_y_i (seg[1]),
    .seg1_end_x_i   (seg[2]),
    .seg1_end_y_i   (seg[3]),
    .seg2_start_x_i (seg[4]),
    .seg2_start_y_i (seg[5]),
    .seg2_end_x_i   (seg[6]),
    .seg2_end_y_i   (seg[7]),
    .tolerance_we_i (tolerance_we_i),
    .tolerance_i    (tolerance_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .parallel_o     (parallel_o),
    .cross_x_o      (cross_x_o),
    .cross_y_o      (cross_y_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_crossing(hit_o, parallel_o, cross_x_o, cross_y_o);
    end
    if (rst_ni && (done_o || (start && !busy))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("segment_intersection_test NOT OK");
      $finish;
    end
  end

  // Called at a falling edge; leaves the bench at a falling edge.
  task send_segments(pair_t p);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 9) < 4) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    seg = p;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_segments(p);
    @(negedge clk_i);
  endtask

  task drain;
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_tolerance(logic [seg_int_pkg::TOL_W-1:0] v);
    drain();
    tolerance_i = v;
    tolerance_we_i = 1'b1;
    @(negedge clk_i);
    tolerance_we_i = 1'b0;
    sb.tol = v;
  endtask

  function coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  function coord_t near(coord_t c, int unsigned span);
    return c + $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  function pair_t make_segments();
    pair_t p;
    coord_t px, py, dx, dy, ox, oy;
    int unsigned span;
    span = 1 << $urandom_range(2, 24);
    case ($urandom_range(0, 9))
      0, 1: foreach (p[i]) p[i] = $urandom;
      2: foreach (p[i]) p[i] = pick_extreme();
      3: begin
        foreach (p[i]) p[i] = $signed($urandom_range(0, 2 * span)) - $signed(span);
      end
      4: begin
        for (int i = 0; i < 4; i++) p[i] = $signed($urandom_range(0, 2 * span)) - $signed(span);
        ox = $signed($urandom_range(0, span)) - $signed(span / 2);
        oy = ($urandom_range(0, 2) == 0) ? 0 : $signed($urandom_range(0, span));
        p[4] = p[0] + ox; p[5] = p[1] + oy;
        p[6] = p[2] + ox; p[7] = p[3] + oy;
        if ($urandom_range(0, 3) == 0) begin
          p[6] = p[4]; p[7] = p[5];
        end
      end
      5: begin
        // tiny determinant with long segments
        p[0] = $urandom; p[1] = $urandom;
        p[2] = p[0] + 32'sh40000000; p[3] = p[1] + 1;
        p[4] = near(p[0], 8); p[5] = near(p[1], 8);
        p[6] = p[4] + 32'sh40000000; p[7] = p[5] + $signed($urandom_range(0, 2));
      end
      default: begin
        px = $signed($urandom_range(0, 2 * span)) - $signed(span);
        py = $signed($urandom_range(0, 2 * span)) - $signed(span);
        dx = $signed($urandom_range(0, span)) - $signed(span / 2);
        dy = $signed($urandom_range(0, span)) - $signed(span / 2);
        p[0] = px - dx; p[1] = py - dy; p[2] = near(px + dx, 3); p[3] = near(py + dy, 3);
        dx = $signed($urandom_range(0, span)) - $signed(span / 2);
        dy = $signed($urandom_range(0, span)) - $signed(span / 2);
        p[4] = px + dx; p[5] = py + dy; p[6] = px - dx; p[7] = py - dy;
        if ($urandom_range(0, 3) == 0) begin
          p[6] = px + $signed($urandom_range(0, 400)) - 200;
          p[7] = py + $signed($urandom_range(0, 400)) - 200;
        end
      end
    endcase
    return p;
  endfunction

  initial begin
    logic [seg_int_pkg::TOL_W-1:0] tol_plan [6];
    tol_plan = '{16'd0, 16'd65535, 16'd1, 16'd131, 16'd4000, 16'd20};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset tolerance: crossing, miss, parallel, degenerate, extremes
    send_segments('{0, 0, 32'sh20000, 32'sh20000, 0, 32'sh20000, 32'sh20000, 0});
    send_segments('{0, 0, 32'sh10000, 0, 32'sh30000, -32'sh10000, 32'sh30000, 32'sh10000});
    send_segments('{0, 0, 32'sh10000, 32'sh10000, 0, 32'sh5, 32'sh10000, 32'sh10005});
    send_segments('{7, 7, 7, 7, 7, 7, 7, 7});
    send_segments('{0, 0, 32'sh10000, 0, 32'sh10000, 0, 32'sh20000, 0});
    send_segments('{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                    32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000});
    send_segments('{32'sh7fffffff, 0, 32'sh80000000, 0, 0, 32'sh7fffffff, 0, 32'sh80000000});
    send_segments('{0, 0, 32'sh7fffffff, 1, 0, 1, 32'sh7ffffffe, 2});
    send_segments('{0, 0, 32'sh7fffffff, 1, 0, -1, 32'sh7fffffff, 1});
    send_segments('{-1, -1, -1, -1, 0, 0, 1, 1});
    // endpoint just outside by the tolerance and by one more
    send_segments('{0, 0, 1000, 0, 1131, -50, 1131, 50});
    send_segments('{0, 0, 1000, 0, 1132, -50, 1132, 50});
    send_segments('{0, 0, 1000, 0, -131, -50, -131, 50});
    send_segments('{0, 0, 1000, 0, -132, -50, -132, 50});

    foreach (tol_plan[k]) begin
      write_tolerance(tol_plan[k]);
      send_segments('{0, 0, 1000, 0, 1000 + tol_plan[k], -50, 1000 + tol_plan[k], 50});
      send_segments('{0, 0, 1000, 0, 1001 + tol_plan[k], -50, 1001 + tol_plan[k], 50});
      for (int n = 0; n < 240; n++) send_segments(make_segments());
      write_tolerance(seg_int_pkg::TOL_W'($urandom_range(0, 65535)));
      for (int n = 0; n < 10; n++) send_segments(make_segments());
    end

    drain();
    repeat (seg_int_pkg::LATENCY + 10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("segment_intersection_test OK");
    end else begin
      $display("segment_intersection_test NOT OK");
    end
    $finish;
  end

endmodule
